// ===== rtl/wps_pkg.sv =====
package wps_pkg;

  // Stream widths
  localparam int unsigned SIN_TDATA_W  = 8;
  localparam int unsigned SIN_TUSER_W  = 2;
  localparam int unsigned MOUT_TDATA_W = 104;
  localparam int unsigned MOUT_TUSER_W = 2;

  // Input word kind (slave tuser)
  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_END  = 2'd1,
    MODE_NEW  = 2'd2
  } mode_e;

  // Result kind (master tuser)
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_RIFF     = 4'd0,
    ERR_WAVE     = 4'd1,
    ERR_FMT_TAG  = 4'd2,
    ERR_FMT_SIZE = 4'd3,
    ERR_NOT_PCM  = 4'd4,
    ERR_CHANNELS = 4'd5,
    ERR_ALIGN    = 4'd6,
    ERR_BITS     = 4'd7,
    ERR_DATA_TAG = 4'd8,
    ERR_TRUNC    = 4'd9
  } err_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_e;

  // Header tags, little-endian as shifted in
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_SIZE = 32'd16;
  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [15:0] BITS_16  = 16'd16;
  localparam logic [15:0] ALIGN_MONO   = 16'd2;
  localparam logic [15:0] ALIGN_STEREO = 16'd4;

  // Header byte offsets at which a field is complete
  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE = 6'd19;
  localparam logic [5:0] POS_FORMAT   = 6'd21;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_ALIGN    = 6'd33;
  localparam logic [5:0] POS_BITS     = 6'd35;
  localparam logic [5:0] POS_DATA     = 6'd39;
  localparam logic [5:0] POS_SIZE     = 6'd43;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        rate_hz;
    logic [30:0]        frame_count;
    logic [1:0]         channel_count;
    err_e               error_code;
    logic               last_frame;
  } result_t;

endpackage

// ===== rtl/wps_in_stage.sv =====
module wps_in_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [wps_pkg::SIN_TDATA_W-1:0]    s_axis_tdata_i,  // byte_value
  input  logic [wps_pkg::SIN_TUSER_W-1:0]    s_axis_tuser_i,  // mode
  input  logic                               advance_i,
  output logic                               item_valid_o,
  output wps_pkg::in_item_t                  item_o
);

  logic              valid_q, valid_d;
  wps_pkg::in_item_t item_q;
  logic              take;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.mode       <= s_axis_tuser_i;
      item_q.byte_value <= s_axis_tdata_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/wps_parse.sv =====
module wps_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  wps_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output wps_pkg::result_t   res_o
);

  wps_pkg::phase_e phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] fb_q, fb_d;
  logic        stereo_q, stereo_d;
  logic [31:0] rate_q, rate_d;
  logic [30:0] frames_q, frames_d;
  logic [1:0]  fbp_q, fbp_d;
  logic [15:0] left_q, left_d;

  logic [31:0] fb_next;
  logic [15:0] half;
  logic [15:0] sample;
  logic [30:0] frames_ann;

  assign fb_next    = {item_i.byte_value, fb_q[31:8]};
  assign half       = fb_next[31:16];
  assign sample     = {item_i.byte_value, fb_q[7:0]};
  // data size / block align: align is 2 or 4
  assign frames_ann = stereo_q ? {1'b0, fb_next[31:2]} : fb_next[31:1];

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    fb_d        = fb_q;
    stereo_d    = stereo_q;
    rate_d      = rate_q;
    frames_d    = frames_q;
    fbp_d       = fbp_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire_i) begin
      case (item_i.mode)
        wps_pkg::MODE_NEW: begin
          phase_d  = wps_pkg::PH_HEADER;
          pos_d    = '0;
          fb_d     = '0;
          stereo_d = 1'b0;
          rate_d   = '0;
          frames_d = '0;
          fbp_d    = '0;
          left_d   = '0;
        end
        wps_pkg::MODE_END: begin
          if (phase_q == wps_pkg::PH_HEADER || phase_q == wps_pkg::PH_DATA) begin
            phase_d           = wps_pkg::PH_IDLE;
            res_valid_o       = 1'b1;
            res_o.kind        = wps_pkg::KIND_ERROR;
            res_o.error_code  = wps_pkg::ERR_TRUNC;
          end
        end
        wps_pkg::MODE_BYTE: begin
          if (phase_q == wps_pkg::PH_HEADER) begin
            fb_d  = fb_next;
            pos_d = pos_q + 6'd1;
            res_o.kind = wps_pkg::KIND_ERROR;
            case (pos_q)
              wps_pkg::POS_RIFF: begin
                if (fb_next != wps_pkg::TAG_RIFF) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_RIFF;
                end
              end
              wps_pkg::POS_WAVE: begin
                if (fb_next != wps_pkg::TAG_WAVE) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_WAVE;
                end
              end
              wps_pkg::POS_FMT: begin
                if (fb_next != wps_pkg::TAG_FMT) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_FMT_TAG;
                end
              end
              wps_pkg::POS_FMT_SIZE: begin
                if (fb_next != wps_pkg::FMT_SIZE) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_FMT_SIZE;
                end
              end
              wps_pkg::POS_FORMAT: begin
                if (half != wps_pkg::FMT_PCM) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_NOT_PCM;
                end
              end
              wps_pkg::POS_CHANNELS: begin
                if (half == 16'd1 || half == 16'd2) begin
                  stereo_d = (half == 16'd2);
                end else begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_CHANNELS;
                end
              end
              wps_pkg::POS_RATE: begin
                rate_d = fb_next;
              end
              wps_pkg::POS_ALIGN: begin
                if (half != (stereo_q ? wps_pkg::ALIGN_STEREO : wps_pkg::ALIGN_MONO)) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_ALIGN;
                end
              end
              wps_pkg::POS_BITS: begin
                if (half != wps_pkg::BITS_16) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_BITS;
                end
              end
              wps_pkg::POS_DATA: begin
                if (fb_next != wps_pkg::TAG_DATA) begin
                  res_valid_o = 1'b1; res_o.error_code = wps_pkg::ERR_DATA_TAG;
                end
              end
              wps_pkg::POS_SIZE: begin
                frames_d            = frames_ann;
                fbp_d               = '0;
                phase_d             = (frames_ann == '0) ? wps_pkg::PH_DONE
                                                         : wps_pkg::PH_DATA;
                res_valid_o         = 1'b1;
                res_o.kind          = wps_pkg::KIND_HEADER;
                res_o.rate_hz       = rate_q;
                res_o.frame_count   = frames_ann;
                res_o.channel_count = stereo_q ? 2'd2 : 2'd1;
                res_o.last_frame    = (frames_ann == '0);
              end
              default: ;
            endcase
            if (res_valid_o && res_o.kind == wps_pkg::KIND_ERROR) begin
              phase_d = wps_pkg::PH_IDLE;
            end
          end else if (phase_q == wps_pkg::PH_DATA) begin
            if (!fbp_q[0]) begin
              fb_d  = {24'd0, item_i.byte_value};
              fbp_d = fbp_q + 2'd1;
            end else if (stereo_q && fbp_q == 2'd1) begin
              left_d = sample;
              fbp_d  = 2'd2;
            end else begin
              fbp_d    = '0;
              frames_d = frames_q - 31'd1;
              if (frames_d == '0) begin
                phase_d = wps_pkg::PH_DONE;
              end
              res_valid_o        = 1'b1;
              res_o.kind         = wps_pkg::KIND_SAMPLE;
              res_o.left_sample  = stereo_q ? left_q : sample;
              res_o.right_sample = sample;
              res_o.last_frame   = (frames_d == '0);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wps_pkg::PH_HEADER;
      pos_q    <= '0;
      fb_q     <= '0;
      stereo_q <= 1'b0;
      rate_q   <= '0;
      frames_q <= '0;
      fbp_q    <= '0;
      left_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      fb_q     <= fb_d;
      stereo_q <= stereo_d;
      rate_q   <= rate_d;
      frames_q <= frames_d;
      fbp_q    <= fbp_d;
      left_q   <= left_d;
    end
  end

endmodule

// ===== rtl/wps_out_stage.sv =====
module wps_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  wps_pkg::result_t                  res_i,
  output logic                              free_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [wps_pkg::MOUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic [wps_pkg::MOUT_TUSER_W-1:0]  m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  logic             valid_q, valid_d;
  wps_pkg::result_t res_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last_frame;
  assign m_axis_tdata_o  = {3'b000, res_q.error_code, res_q.channel_count,
                            res_q.frame_count, res_q.rate_hz,
                            res_q.right_sample, res_q.left_sample};

endmodule

// ===== rtl/wav_pcm16_stream_parser.sv =====
// WAV PCM16 stream parser: byte-wide file stream in, header/frame/error words out.
// Pipeline: a word accepted into the input register is parsed combinationally there,
// and its result word, if it yields one, is loaded into the result register once
// that register can take it (is empty or being drained).
// Throughput: one word per cycle; the only stall is a full result register.
// Reset (rst_ni low, asynchronous): empty pipeline, parser in header phase.
module wav_pcm16_stream_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [wps_pkg::SIN_TDATA_W-1:0]   s_axis_tdata_i,   // [7:0] byte_value
  input  logic [wps_pkg::SIN_TUSER_W-1:0]   s_axis_tuser_i,   // [1:0] mode
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] left_sample, [31:16] right_sample, [63:32] rate_hz,
  // [94:64] frame_count, [96:95] channel_count, [100:97] error_code, rest zero
  output logic [wps_pkg::MOUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic [wps_pkg::MOUT_TUSER_W-1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic                              m_axis_tlast_o    // last_frame
);

  logic              item_valid;
  wps_pkg::in_item_t item;
  logic              out_free;
  logic              fire;
  logic              res_valid;
  wps_pkg::result_t  res;

  // A buffered word is consumed whenever the result register can take
  // whatever it may produce.
  assign fire = item_valid && out_free;

  wps_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .advance_i       (fire),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  // Header checks, field capture and sample assembly
  wps_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wps_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (fire && res_valid),
    .res_i           (res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== rtl/wps_checker.sv =====
module wps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [wps_pkg::MOUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic [wps_pkg::MOUT_TUSER_W-1:0]  m_axis_tuser_o,
  input logic                              m_axis_tlast_o
);

  // Stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result word changed");

  a_no_last_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == wps_pkg::KIND_ERROR |-> !m_axis_tlast_o)
    else $error("error word marked last");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == wps_pkg::KIND_ERROR |->
      m_axis_tdata_o[100:97] <= wps_pkg::ERR_TRUNC && m_axis_tdata_o[96:0] == '0)
    else $error("bad error word");

  a_sample_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == wps_pkg::KIND_SAMPLE |->
      m_axis_tdata_o[103:32] == '0)
    else $error("sample word carries header or error fields");

  a_header_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == wps_pkg::KIND_HEADER |->
      (m_axis_tdata_o[96:95] == 2'd1 || m_axis_tdata_o[96:95] == 2'd2)
      && m_axis_tlast_o == (m_axis_tdata_o[94:64] == '0))
    else $error("bad header word");

endmodule

bind wav_pcm16_stream_parser wps_checker u_wps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== tb/wav_pcm16_stream_parser_test.sv =====
module wav_pcm16_stream_parser_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;   // reserved word kind, must be ignored
  localparam int unsigned IDLE_LIMIT = 3000;   // cycles with no handshake at all
  localparam int unsigned WORD_BUDGET = 1050;
  localparam int unsigned SQUEEZE_AT = 400;    // input words taken before the long hold
  localparam int unsigned SQUEEZE_LEN = 300;

  typedef enum {FIN_CLEAN, FIN_TRUNC_END, FIN_TRUNC_NEW, FIN_HDR_END} ending_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] byte_value
  logic [1:0]  s_tuser = '0;     // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [103:0] m_tdata;         // left, right, rate, frames, channels, error, pad
  logic [1:0]  m_tuser;          // [1:0] kind
  logic        m_tlast;

  wav_pcm16_stream_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: header checks, frame assembly, error latch
  // ---------------------------------------------------------------------------
  wps_pkg::phase_e wav_phase = wps_pkg::PH_HEADER;
  logic [5:0]  wav_pos = '0;
  logic [31:0] wav_shift = '0;      // last four bytes, little-endian
  logic        wav_stereo = 1'b0;
  logic [31:0] wav_rate = '0;
  logic [30:0] wav_frames_left = '0;
  logic [1:0]  wav_fpos = '0;       // byte slot within the current frame
  logic [15:0] wav_left = '0;

  function automatic void wav_clear();
    wav_phase = wps_pkg::PH_HEADER;
    wav_pos = '0;
    wav_shift = '0;
    wav_stereo = 1'b0;
    wav_rate = '0;
    wav_frames_left = '0;
    wav_fpos = '0;
    wav_left = '0;
  endfunction

  function automatic bit wav_raise(input wps_pkg::err_e code, output wps_pkg::result_t r);
    wav_phase = wps_pkg::PH_IDLE;
    r = '0;
    r.kind = wps_pkg::KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  // Returns 1 when the word yields a result word
  function automatic bit wav_predict(input logic [1:0] mode, input logic [7:0] b,
                                     output wps_pkg::result_t r);
    logic [5:0]  pos;
    logic [15:0] half;
    logic [15:0] align;
    logic [15:0] smp;
    logic [31:0] quot;
    bit          hit;
    r = '0;
    hit = 1'b0;
    case (mode)
      wps_pkg::MODE_NEW: wav_clear();
      wps_pkg::MODE_END: begin
        if (wav_phase == wps_pkg::PH_HEADER || wav_phase == wps_pkg::PH_DATA) begin
          hit = wav_raise(wps_pkg::ERR_TRUNC, r);
        end
      end
      wps_pkg::MODE_BYTE: begin
        if (wav_phase == wps_pkg::PH_HEADER) begin
          pos = wav_pos;
          wav_shift = {b, wav_shift[31:8]};
          wav_pos = pos + 6'd1;
          half = wav_shift[31:16];
          align = wav_stereo ? wps_pkg::ALIGN_STEREO : wps_pkg::ALIGN_MONO;
          case (pos)
            wps_pkg::POS_RIFF:
              if (wav_shift != wps_pkg::TAG_RIFF) hit = wav_raise(wps_pkg::ERR_RIFF, r);
            wps_pkg::POS_WAVE:
              if (wav_shift != wps_pkg::TAG_WAVE) hit = wav_raise(wps_pkg::ERR_WAVE, r);
            wps_pkg::POS_FMT:
              if (wav_shift != wps_pkg::TAG_FMT) hit = wav_raise(wps_pkg::ERR_FMT_TAG, r);
            wps_pkg::POS_FMT_SIZE:
              if (wav_shift != wps_pkg::FMT_SIZE) hit = wav_raise(wps_pkg::ERR_FMT_SIZE, r);
            wps_pkg::POS_FORMAT:
              if (half != wps_pkg::FMT_PCM) hit = wav_raise(wps_pkg::ERR_NOT_PCM, r);
            wps_pkg::POS_CHANNELS: begin
              if (half < 16'd1 || half > 16'd2) hit = wav_raise(wps_pkg::ERR_CHANNELS, r);
              else wav_stereo = (half == 16'd2);
            end
            wps_pkg::POS_RATE:     wav_rate = wav_shift;
            wps_pkg::POS_ALIGN:
              if (half != align) hit = wav_raise(wps_pkg::ERR_ALIGN, r);
            wps_pkg::POS_BITS:
              if (half != wps_pkg::BITS_16) hit = wav_raise(wps_pkg::ERR_BITS, r);
            wps_pkg::POS_DATA:
              if (wav_shift != wps_pkg::TAG_DATA) hit = wav_raise(wps_pkg::ERR_DATA_TAG, r);
            wps_pkg::POS_SIZE: begin
              // data size is unsigned; frames = size / block align
              quot = wav_shift / {16'd0, align};
              wav_frames_left = quot[30:0];
              wav_fpos = '0;
              wav_phase = (wav_frames_left == '0) ? wps_pkg::PH_DONE : wps_pkg::PH_DATA;
              r.kind = wps_pkg::KIND_HEADER;
              r.rate_hz = wav_rate;
              r.frame_count = wav_frames_left;
              r.channel_count = wav_stereo ? 2'd2 : 2'd1;
              r.last_frame = (wav_frames_left == '0);
              hit = 1'b1;
            end
            default: ;
          endcase
        end else if (wav_phase == wps_pkg::PH_DATA) begin
          if (!wav_fpos[0]) begin
            // low byte of a sample
            wav_shift = {24'd0, b};
            wav_fpos = wav_fpos + 2'd1;
          end else begin
            smp = {b, wav_shift[7:0]};
            if (wav_stereo && wav_fpos == 2'd1) begin
              wav_left = smp;
              wav_fpos = 2'd2;
            end else begin
              wav_fpos = '0;
              wav_frames_left = wav_frames_left - 31'd1;
              r.kind = wps_pkg::KIND_SAMPLE;
              r.left_sample = wav_stereo ? wav_left : smp;
              r.right_sample = smp;
              r.last_frame = (wav_frames_left == '0);
              if (r.last_frame) wav_phase = wps_pkg::PH_DONE;
              hit = 1'b1;
            end
          end
        end
      end
      default: ;   // unused kind: no effect
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: WAV files built byte by byte
  // ---------------------------------------------------------------------------
  wps_pkg::in_item_t file_words[$];
  int unsigned words_queued = 0;
  logic [7:0]  hdr [44];

  task automatic queue_word(input logic [1:0] mode, input logic [7:0] b);
    wps_pkg::in_item_t w;
    w.mode = mode;
    w.byte_value = b;
    file_words.push_back(w);
    words_queued++;
  endtask

  // data byte, now and then preceded by a stray reserved-kind word
  task automatic queue_byte(input logic [7:0] b);
    if ($urandom_range(0, 59) == 0) queue_word(MODE_UNUSED, 8'($urandom));
    queue_word(wps_pkg::MODE_BYTE, b);
  endtask

  function automatic void hdr_put(input int at, input int n, input logic [31:0] v);
    for (int i = 0; i < n; i++) hdr[at + i] = v[8*i +: 8];
  endfunction

  function automatic void hdr_flip_tag(input int at);
    hdr[at + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] other16(input logic [15:0] want);
    logic [15:0] v;
    if ($urandom_range(0, 1) == 0) begin
      v = want ^ (16'd1 << $urandom_range(0, 15));
    end else begin
      do v = 16'($urandom); while (v == want);
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd44100;
      3: return 32'd48000;
      default: return $urandom;
    endcase
  endfunction

  // One file: new-file mark, header (maybe broken at one check), samples, ending
  task automatic queue_file(input bit broken, input wps_pkg::err_e bad,
                            input int unsigned ch, input int unsigned frames,
                            input bit huge, input ending_e fin);
    logic [31:0] size;
    logic [15:0] smp;
    int unsigned align;
    int unsigned stop;
    int unsigned nbytes;
    align = 2 * ch;
    if (huge) size = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
    else size = frames * align + $urandom_range(0, align - 1);
    hdr_put(int'(wps_pkg::POS_RIFF) - 3, 4, wps_pkg::TAG_RIFF);
    hdr_put(int'(wps_pkg::POS_RIFF) + 1, 4, $urandom);          // riff size, ignored
    hdr_put(int'(wps_pkg::POS_WAVE) - 3, 4, wps_pkg::TAG_WAVE);
    hdr_put(int'(wps_pkg::POS_FMT) - 3, 4, wps_pkg::TAG_FMT);
    hdr_put(int'(wps_pkg::POS_FMT_SIZE) - 3, 4, wps_pkg::FMT_SIZE);
    hdr_put(int'(wps_pkg::POS_FORMAT) - 1, 2, {16'd0, wps_pkg::FMT_PCM});
    hdr_put(int'(wps_pkg::POS_CHANNELS) - 1, 2, ch);
    hdr_put(int'(wps_pkg::POS_RATE) - 3, 4, pick_rate());
    hdr_put(int'(wps_pkg::POS_RATE) + 1, 4, $urandom);          // byte rate, ignored
    hdr_put(int'(wps_pkg::POS_ALIGN) - 1, 2, align);
    hdr_put(int'(wps_pkg::POS_BITS) - 1, 2, {16'd0, wps_pkg::BITS_16});
    hdr_put(int'(wps_pkg::POS_DATA) - 3, 4, wps_pkg::TAG_DATA);
    hdr_put(int'(wps_pkg::POS_SIZE) - 3, 4, size);
    stop = wps_pkg::POS_SIZE;
    if (broken) begin
      case (bad)
        wps_pkg::ERR_RIFF: begin
          hdr_flip_tag(int'(wps_pkg::POS_RIFF) - 3);
          stop = wps_pkg::POS_RIFF;
        end
        wps_pkg::ERR_WAVE: begin
          hdr_flip_tag(int'(wps_pkg::POS_WAVE) - 3);
          stop = wps_pkg::POS_WAVE;
        end
        wps_pkg::ERR_FMT_TAG: begin
          hdr_flip_tag(int'(wps_pkg::POS_FMT) - 3);
          stop = wps_pkg::POS_FMT;
        end
        wps_pkg::ERR_DATA_TAG: begin
          hdr_flip_tag(int'(wps_pkg::POS_DATA) - 3);
          stop = wps_pkg::POS_DATA;
        end
        wps_pkg::ERR_FMT_SIZE: begin
          hdr_put(int'(wps_pkg::POS_FMT_SIZE) - 3, 4,
                  ($urandom_range(0, 1) == 0) ?
                  (wps_pkg::FMT_SIZE ^ (32'd1 << $urandom_range(0, 31))) :
                  ($urandom | 32'h100));
          stop = wps_pkg::POS_FMT_SIZE;
        end
        wps_pkg::ERR_NOT_PCM: begin
          hdr_put(int'(wps_pkg::POS_FORMAT) - 1, 2, other16(wps_pkg::FMT_PCM));
          stop = wps_pkg::POS_FORMAT;
        end
        wps_pkg::ERR_CHANNELS: begin
          hdr_put(int'(wps_pkg::POS_CHANNELS) - 1, 2,
                  ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3, 65535));
          stop = wps_pkg::POS_CHANNELS;
        end
        wps_pkg::ERR_ALIGN: begin
          hdr_put(int'(wps_pkg::POS_ALIGN) - 1, 2, other16(16'(align)));
          stop = wps_pkg::POS_ALIGN;
        end
        default: begin
          hdr_put(int'(wps_pkg::POS_BITS) - 1, 2, other16(wps_pkg::BITS_16));
          stop = wps_pkg::POS_BITS;
        end
      endcase
    end
    if (fin == FIN_HDR_END) stop = $urandom_range(0, int'(wps_pkg::POS_SIZE) - 1);
    queue_word(wps_pkg::MODE_NEW, 8'($urandom));
    for (int i = 0; i <= int'(stop); i++) queue_byte(hdr[i]);
    if (broken) begin
      // parser is latched in error: all of this must be ignored
      repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));
      if ($urandom_range(0, 1) == 0) queue_word(wps_pkg::MODE_END, 8'($urandom));
      return;
    end
    if (fin == FIN_HDR_END) begin
      queue_word(wps_pkg::MODE_END, 8'($urandom));
      return;
    end
    nbytes = huge ? $urandom_range(0, 48) : frames * align;
    if ((fin == FIN_TRUNC_END || fin == FIN_TRUNC_NEW) && !huge && nbytes > 0)
      nbytes = $urandom_range(0, nbytes - 1);
    for (int i = 0; i < int'(nbytes); i += 2) begin
      smp = pick_sample();
      queue_byte(smp[7:0]);
      if (i + 1 < int'(nbytes)) queue_byte(smp[15:8]);
    end
    if (huge || fin == FIN_TRUNC_END) begin
      queue_word(wps_pkg::MODE_END, 8'($urandom));
    end else if (fin == FIN_CLEAN) begin
      repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));   // trailing junk
      if ($urandom_range(0, 1) == 0) queue_word(wps_pkg::MODE_END, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps
  // ---------------------------------------------------------------------------
  wps_pkg::result_t pending_results[$];
  int unsigned words_taken = 0;
  int unsigned burst_left = 24;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : drive
    wps_pkg::in_item_t w;
    wps_pkg::result_t  r;
    bit                nxt_valid;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        if (wav_predict(s_tuser, s_tdata, r)) pending_results.push_back(r);
        words_taken++;
      end
      if (!s_tvalid || s_tready) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (file_words.size() != 0) begin
          w = file_words.pop_front();
          nxt_valid = 1'b1;
          s_tdata <= w.byte_value;
          s_tuser <= w.mode;
          burst_left--;
          if (burst_left == 0) begin
            // long unbroken stretches now and then
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        s_tvalid <= nxt_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: one of four stall styles, picked again at regular intervals, plus one long hold
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  int unsigned rx_style = 0;
  int unsigned squeeze_left = 0;
  bit          squeeze_done = 1'b0;

  always @(posedge clk_i) begin : receive
    bit rdy;
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
      if (!squeeze_done && words_taken >= SQUEEZE_AT) begin
        squeeze_left = SQUEEZE_LEN;
        squeeze_done = 1'b1;
      end
      case (rx_style)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycle % 3 == 0);
      endcase
      if (squeeze_left != 0) begin
        squeeze_left--;
        rdy = 1'b0;
      end
      m_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check, field by field against the oldest expectation
  // ---------------------------------------------------------------------------
  int unsigned errors = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    wps_pkg::result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none got kind %h data %h last %b",
                 $time, m_tuser, m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, m_tuser);
        // samples compared as raw 16-bit patterns
        check_field("left_sample", {16'd0, want.left_sample}, m_tdata[15:0]);
        check_field("right_sample", {16'd0, want.right_sample}, m_tdata[31:16]);
        check_field("rate_hz", want.rate_hz, m_tdata[63:32]);
        check_field("frame_count", want.frame_count, m_tdata[94:64]);
        check_field("channel_count", want.channel_count, m_tdata[96:95]);
        check_field("error_code", want.error_code, m_tdata[100:97]);
        check_field("pad", 32'd0, m_tdata[103:101]);
        check_field("last_frame", want.last_frame, m_tlast);
      end
    end
  end

  // Watchdog: no handshake on either side for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: stream stuck", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed words, forced scenarios, random files, drain
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sel;
    int unsigned ch;
    int unsigned frames;
    wav_clear();

    // end right after reset, then everything ignored while latched
    queue_word(wps_pkg::MODE_END, 8'h00);
    queue_word(wps_pkg::MODE_END, 8'hFF);
    queue_word(MODE_UNUSED, 8'hA5);
    queue_word(wps_pkg::MODE_BYTE, 8'hFF);
    // bad RIFF tag, then junk in the error state
    queue_word(wps_pkg::MODE_NEW, 8'h00);
    queue_word(wps_pkg::MODE_BYTE, "R");
    queue_word(wps_pkg::MODE_BYTE, "I");
    queue_word(wps_pkg::MODE_BYTE, "F");
    queue_word(wps_pkg::MODE_BYTE, "G");
    queue_word(wps_pkg::MODE_BYTE, 8'h00);
    queue_word(wps_pkg::MODE_END, 8'h5A);
    // good tag, reserved kind mid-header, stream ends inside the header
    queue_word(wps_pkg::MODE_NEW, 8'hFF);
    queue_word(wps_pkg::MODE_BYTE, "R");
    queue_word(wps_pkg::MODE_BYTE, "I");
    queue_word(MODE_UNUSED, 8'h00);
    queue_word(wps_pkg::MODE_BYTE, "F");
    queue_word(wps_pkg::MODE_BYTE, "F");
    queue_word(wps_pkg::MODE_BYTE, 8'h00);
    queue_word(wps_pkg::MODE_BYTE, 8'hFF);
    queue_word(wps_pkg::MODE_END, 8'h00);

    // every header check broken once, then key good-file shapes
    for (int e = 0; e <= int'(wps_pkg::ERR_DATA_TAG); e++)
      queue_file(1'b1, wps_pkg::err_e'(e), $urandom_range(1, 2), 2, 1'b0, FIN_CLEAN);
    queue_file(1'b0, wps_pkg::ERR_RIFF, 2, 6, 1'b0, FIN_CLEAN);
    queue_file(1'b0, wps_pkg::ERR_RIFF, 1, 0, 1'b0, FIN_CLEAN);
    queue_file(1'b0, wps_pkg::ERR_RIFF, 1, 0, 1'b1, FIN_CLEAN);
    queue_file(1'b0, wps_pkg::ERR_RIFF, 2, 0, 1'b1, FIN_CLEAN);
    queue_file(1'b0, wps_pkg::ERR_RIFF, 2, 5, 1'b0, FIN_TRUNC_END);

    while (words_queued < WORD_BUDGET) begin
      sel = $urandom_range(0, 19);
      ch = $urandom_range(1, 2);
      frames = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (sel < 11) queue_file(1'b0, wps_pkg::ERR_RIFF, ch, frames, 1'b0, FIN_CLEAN);
      else if (sel < 13) queue_file(1'b0, wps_pkg::ERR_RIFF, ch, frames, 1'b0, FIN_TRUNC_END);
      else if (sel == 13) queue_file(1'b0, wps_pkg::ERR_RIFF, ch, frames, 1'b0, FIN_TRUNC_NEW);
      else if (sel == 14) queue_file(1'b0, wps_pkg::ERR_RIFF, ch, frames, 1'b0, FIN_HDR_END);
      else if (sel == 15) queue_file(1'b0, wps_pkg::ERR_RIFF, ch, frames, 1'b1, FIN_CLEAN);
      else if (sel < 19) begin
        queue_file(1'b1, wps_pkg::err_e'($urandom_range(0, int'(wps_pkg::ERR_DATA_TAG))),
                   ch, frames, 1'b0, FIN_CLEAN);
      end else begin
        // raw noise after a new-file mark
        queue_word(wps_pkg::MODE_NEW, 8'($urandom));
        repeat ($urandom_range(4, 16)) queue_word(2'($urandom), 8'($urandom));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (file_words.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    // two-stage pipeline: allow any stray word to surface
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
